// File: rtl/sha256_pkg.sv
// sha256_pkg: shared types, constants and helper functions for the sha-256 core
// depends on nothing; imported by sha256_ctrl, sha256_dp and sha256_message_digest
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  fill_t;
  typedef logic [5:0]  round_t;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenBytes   = 8;
  localparam int unsigned HashWords  = 8;
  localparam int unsigned SchedWords = 16;

  localparam fill_t  LastFill  = fill_t'(BlockBytes - 1);
  localparam fill_t  LenFill   = fill_t'(BlockBytes - LenBytes);
  localparam round_t LastRound = round_t'(RoundCount - 1);

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [63:0] BitsPerByte = 64'd8;
  localparam logic [1:0]  LastWordIdx = 2'd3;

  localparam word_t RoundK [RoundCount] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam word_t HashInit [HashWords] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_ZERO,
    ST_LEN,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  // where to go once a compression has finished
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD80,
    RET_ZERO,
    RET_OUT
  } ret_e;

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      shift_byte;
    byte_sel_e byte_sel;
    logic [2:0] len_idx;
    logic      count_byte;
    logic      init_work;
    logic      round;
    round_t    round_idx;
    logic      add_hash;
    logic      clear;
    logic [1:0] word_idx;
  } dp_cmd_t;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: rtl/sha256_in_if.sv
// sha256_in_if: message byte channel, valid/ready handshake
// no dependencies
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input end_of_message,
                output ready);
endinterface

// File: rtl/sha256_out_if.sv
// sha256_out_if: digest word channel, valid/ready handshake
// no dependencies
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// File: rtl/sha256_ctrl.sv
// sha256_ctrl: sequencer for byte loading, padding, the 64 rounds and digest output
// depends on sha256_pkg
module sha256_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                has_byte_i,
  input  logic                eom_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          word_idx_o,
  output logic                out_last_o,
  output sha256_pkg::dp_cmd_t cmd_o
);
  import sha256_pkg::*;

  state_e     state_q, state_d;
  ret_e       ret_q, ret_d;
  fill_t      fill_q, fill_d;
  round_t     rnd_q, rnd_d;
  logic [1:0] wcnt_q, wcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= RET_IDLE;
      fill_q  <= '0;
      rnd_q   <= '0;
      wcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      wcnt_q  <= wcnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fill_d  = fill_q;
    rnd_d   = rnd_q;
    wcnt_d  = wcnt_q;
    cmd_o   = '0;
    cmd_o.byte_sel  = BYTE_DATA;
    cmd_o.len_idx   = fill_q[2:0];
    cmd_o.round_idx = rnd_q;
    cmd_o.word_idx  = wcnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (has_byte_i) begin
            cmd_o.shift_byte = 1'b1;
            cmd_o.count_byte = 1'b1;
            fill_d = fill_q + 6'd1;
            if (fill_q == LastFill) begin
              state_d = ST_INIT;
              ret_d   = eom_i ? RET_PAD80 : RET_IDLE;
            end else if (eom_i) begin
              state_d = ST_PAD80;
            end
          end else if (eom_i) begin
            state_d = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd_o.shift_byte = 1'b1;
        cmd_o.byte_sel   = BYTE_PAD;
        fill_d = fill_q + 6'd1;
        if (fill_q == LastFill) begin
          state_d = ST_INIT;
          ret_d   = RET_ZERO;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (fill_q == LenFill) begin
          state_d = ST_LEN;
        end else begin
          cmd_o.shift_byte = 1'b1;
          cmd_o.byte_sel   = BYTE_ZERO;
          fill_d = fill_q + 6'd1;
          // no room for the length: close this block, length goes in the next
          if (fill_q == LastFill) begin
            state_d = ST_INIT;
            ret_d   = RET_ZERO;
          end
        end
      end
      ST_LEN: begin
        cmd_o.shift_byte = 1'b1;
        cmd_o.byte_sel   = BYTE_LEN;
        fill_d = fill_q + 6'd1;
        if (fill_q == LastFill) begin
          state_d = ST_INIT;
          ret_d   = RET_OUT;
        end
      end
      ST_INIT: begin
        cmd_o.init_work = 1'b1;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LastRound) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_hash = 1'b1;
        unique case (ret_q)
          RET_IDLE:  state_d = ST_IDLE;
          RET_PAD80: state_d = ST_PAD80;
          RET_ZERO:  state_d = ST_ZERO;
          RET_OUT:   state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          wcnt_d = wcnt_q + 2'd1;
          if (wcnt_q == LastWordIdx) begin
            cmd_o.clear = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  assign word_idx_o = wcnt_q;
  assign out_last_o = (wcnt_q == LastWordIdx);

endmodule

// File: rtl/sha256_dp.sv
// sha256_dp: schedule shift line, working variables, hash state, bit counter, round unit
// depends on sha256_pkg
module sha256_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha256_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]          data_byte_i,
  output logic [63:0]         digest_o
);
  import sha256_pkg::*;

  word_t       w_q [SchedWords];
  word_t       w_d [SchedWords];
  word_t       v_q [HashWords];
  word_t       v_d [HashWords];
  word_t       h_q [HashWords];
  word_t       h_d [HashWords];
  logic [63:0] bits_q, bits_d;

  logic [7:0] byte_val;
  logic [2:0] len_sel;
  word_t      w_new, t1, t2, ch, maj;

  assign len_sel = 3'd7 - cmd_i.len_idx;

  always_comb begin
    unique case (cmd_i.byte_sel)
      BYTE_DATA: byte_val = data_byte_i;
      BYTE_PAD:  byte_val = PadByte;
      BYTE_ZERO: byte_val = 8'h00;
      BYTE_LEN:  byte_val = bits_q[{len_sel, 3'b000} +: 8];
    endcase
  end

  // w_q[0] is always the current round's word; w_new becomes word t+16
  assign w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + big_sigma1(v_q[4]) + ch + RoundK[cmd_i.round_idx] + w_q[0];
  assign t2    = big_sigma0(v_q[0]) + maj;

  always_comb begin
    for (int i = 0; i < SchedWords; i++) begin
      w_d[i] = w_q[i];
    end
    if (cmd_i.shift_byte) begin
      // whole block moves one byte toward word 0
      for (int i = 0; i < SchedWords - 1; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_d[SchedWords-1] = {w_q[SchedWords-1][23:0], byte_val};
    end else if (cmd_i.round) begin
      for (int i = 0; i < SchedWords - 1; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[SchedWords-1] = w_new;
    end
  end

  always_comb begin
    for (int i = 0; i < HashWords; i++) begin
      v_d[i] = v_q[i];
    end
    if (cmd_i.init_work) begin
      for (int i = 0; i < HashWords; i++) begin
        v_d[i] = h_q[i];
      end
    end else if (cmd_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < HashWords; i++) begin
      h_d[i] = h_q[i];
    end
    bits_d = bits_q;
    if (cmd_i.clear) begin
      for (int i = 0; i < HashWords; i++) begin
        h_d[i] = HashInit[i];
      end
      bits_d = '0;
    end else begin
      if (cmd_i.add_hash) begin
        for (int i = 0; i < HashWords; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
      end
      if (cmd_i.count_byte) begin
        bits_d = bits_q + BitsPerByte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SchedWords; i++) begin
      w_q[i] <= w_d[i];
    end
    for (int i = 0; i < HashWords; i++) begin
      v_q[i] <= v_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HashWords; i++) begin
        h_q[i] <= HashInit[i];
      end
      bits_q <= '0;
    end else begin
      for (int i = 0; i < HashWords; i++) begin
        h_q[i] <= h_d[i];
      end
      bits_q <= bits_d;
    end
  end

  assign digest_o = {h_q[{cmd_i.word_idx, 1'b0}], h_q[{cmd_i.word_idx, 1'b1}]};

endmodule

// File: rtl/sha256_message_digest.sv
// channel  dir  handshake      payload
// msg_i    in   valid/ready    data_byte[7:0], has_byte, end_of_message
// dig_o    out  valid/ready    digest_word[63:0], word_index[1:0], last_word
//
// a byte is taken whenever the controller is idle; every 64th byte then uses the
// single shared round unit (load, 64 rounds, hash add) before more input is taken
// an end-of-message word adds pad and length bytes to the final block, then one
// or two compressions, then four digest words; no input is taken meanwhile
// reset clears the controller and bit count and loads the initial hash state;
// output stalls hold the digest words in the hash registers
// top level: joins sha256_ctrl and sha256_dp; depends on sha256_pkg and both interfaces
module sha256_message_digest (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha256_in_if.sink    msg_i,
  sha256_out_if.source dig_o
);
  import sha256_pkg::*;

  dp_cmd_t    cmd;
  logic [1:0] word_idx;
  logic       out_last;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (msg_i.valid),
    .has_byte_i  (msg_i.has_byte),
    .eom_i       (msg_i.end_of_message),
    .in_ready_o  (msg_i.ready),
    .out_valid_o (dig_o.valid),
    .out_ready_i (dig_o.ready),
    .word_idx_o  (word_idx),
    .out_last_o  (out_last),
    .cmd_o       (cmd)
  );

  sha256_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (msg_i.data_byte),
    .digest_o    (dig_o.digest_word)
  );

  assign dig_o.word_index = word_idx;
  assign dig_o.last_word  = out_last;

endmodule
